// ===== src/mtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Multitap port package
// Shared codes, the per-port state record and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

  localparam int unsigned NumPortsDef = 5;
  localparam int unsigned TypePorts   = 5;

  localparam logic [1:0] KindWrite    = 2'd0;
  localparam logic [1:0] KindRead     = 2'd1;
  localparam logic [1:0] KindPadUpd   = 2'd2;
  localparam logic [1:0] KindMouseUpd = 2'd3;

  localparam logic [1:0] TypeNone  = 2'd0;
  localparam logic [1:0] TypePad   = 2'd1;
  localparam logic [1:0] TypeMouse = 2'd2;
  localparam logic [1:0] TypeAlias = 2'd3;

  localparam logic [1:0] CfgPortTypes = 2'd0;
  localparam logic [1:0] CfgCd        = 2'd1;
  localparam logic [1:0] CfgInterval  = 2'd2;

  localparam logic [15:0] IntervalReset = 16'd10000;
  localparam logic [7:0]  IndexMax      = 8'd255;
  localparam logic [3:0]  NibbleAll     = 4'hF;

  typedef enum logic [2:0] {
    OpIdle,
    OpPadRd,
    OpMouseRd,
    OpPadUpd,
    OpMouseUpd
  } op_e;

  typedef struct packed {
    logic [12:0]        pad_state;
    logic               six_on;
    logic               high_phase;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [15:0]        shift;
    logic [1:0]         buttons;
    logic [31:0]        last_latch;
  } entry_t;

  typedef struct packed {
    op_e                op;
    logic               sel;
    logic [31:0]        now;
    logic [12:0]        pad;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [1:0]         mbtn;
  } stage_t;

  typedef struct packed {
    logic       we;
    logic [3:0] nibble;
  } result_t;

  function automatic logic [1:0] type_of(logic [7:0] p, logic [9:0] pt);
    logic [1:0] t;
    t = 2'(pt >> {p, 1'b0});
    if (p >= 8'(TypePorts) || t == TypeAlias) begin
      t = TypeNone;
    end
    return t;
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    r = s[31:0];
    if (s[32] != s[31]) begin
      r = s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [7:0] neg_clamp(logic signed [31:0] v);
    logic signed [7:0] c;
    if (v > 32'sd127) begin
      c = 8'sd127;
    end else if (v < -32'sd127) begin
      c = -8'sd127;
    end else begin
      c = v[7:0];
    end
    return -c;
  endfunction

endpackage

`default_nettype wire

// ===== src/mtp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/mtp_port_logic.sv =====
// ----------------------------------------------------------------------------
// Multitap port update logic
// Computes the data nibble and the new per-port state for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_port_logic (
  input  wire mtp_pkg::stage_t  item_i,
  input  wire mtp_pkg::entry_t  entry_i,
  input  wire logic [15:0]      interval_i,
  output      mtp_pkg::entry_t  entry_o,
  output      mtp_pkg::result_t res_o
);
  import mtp_pkg::*;

  logic [31:0]       elapsed;
  logic              do_latch;
  logic signed [7:0] rx;
  logic signed [7:0] ry;
  logic [15:0]       shift_new;
  logic              high;

  assign elapsed  = item_i.now - entry_i.last_latch;
  assign do_latch = elapsed > {16'd0, interval_i};
  assign rx       = neg_clamp(entry_i.acc_x);
  assign ry       = neg_clamp(entry_i.acc_y);
  assign shift_new = do_latch ? {ry[3:0], ry[7:4], rx[3:0], rx[7:4]} : entry_i.shift;
  assign high     = entry_i.high_phase && entry_i.six_on;

  always_comb begin
    entry_o = entry_i;
    res_o   = '0;
    unique case (item_i.op)
      OpPadRd: begin
        if (high) begin
          res_o.nibble = item_i.sel ? 4'h0 : (NibbleAll ^ entry_i.pad_state[11:8]);
        end else begin
          res_o.nibble = NibbleAll ^ (item_i.sel ? entry_i.pad_state[7:4]
                                                 : entry_i.pad_state[3:0]);
        end
        if (!item_i.sel) begin
          entry_o.high_phase = !entry_i.high_phase;
          res_o.we = 1'b1;
        end
      end
      OpMouseRd: begin
        if (item_i.sel) begin
          res_o.nibble  = shift_new[3:0];
          entry_o.shift = {4'h0, shift_new[15:4]};
          if (do_latch) begin
            entry_o.last_latch = item_i.now;
            entry_o.acc_x = sat_add(entry_i.acc_x, 32'(rx));
            entry_o.acc_y = sat_add(entry_i.acc_y, 32'(ry));
          end
          res_o.we = 1'b1;
        end else begin
          res_o.nibble = NibbleAll ^ {entry_i.buttons[1], 1'b0,
                                      entry_i.buttons[0], entry_i.buttons[0]};
        end
      end
      OpPadUpd: begin
        entry_o.six_on = entry_i.six_on ^ (item_i.pad[12] && !entry_i.pad_state[12]);
        entry_o.pad_state = item_i.pad;
        res_o.we = 1'b1;
      end
      OpMouseUpd: begin
        entry_o.acc_x   = sat_add(entry_i.acc_x, item_i.dx);
        entry_o.acc_y   = sat_add(entry_i.acc_y, item_i.dy);
        entry_o.buttons = item_i.mbtn;
        res_o.we = 1'b1;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/multitap_joypad_mouse_port.sv =====
// ----------------------------------------------------------------------------
// Multitap joypad and mouse port
// Five-port multitap with gamepads and mice; per-port state lives in a RAM.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/stall     kind, write_value, now, port, pad, mouse
// out      output     out_valid/stall    read_data
// cfg      input      cfg_valid/ready    cfg_index, cfg_data
//
// One item per cycle unless the input stalls. An accepted item enters the stage
// register while the state RAM is read; the RAM data and the update logic share
// that stage, and a read's byte lands in the output register. Back-to-back items
// on one port see the previous write through a forwarding register. Reset clears
// control state and the per-entry valid bits, so unwritten entries read as zero.
// Input stalls only when a read result meets a full, stalled output register.
// ----------------------------------------------------------------------------
`default_nettype none

module multitap_joypad_mouse_port #(
  parameter int unsigned NUM_PORTS = mtp_pkg::NumPortsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [1:0]         write_value_i,
  input  wire logic [31:0]        now_i,
  input  wire logic [2:0]         port_i,
  input  wire logic [12:0]        pad_buttons_i,
  input  wire logic signed [31:0] mouse_dx_i,
  input  wire logic signed [31:0] mouse_dy_i,
  input  wire logic [1:0]         mouse_buttons_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [7:0]         read_data_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);
  import mtp_pkg::*;

  localparam int unsigned AddrW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned Slots = 1 << AddrW;

  logic [9:0]  port_types_q;
  logic        cd_q;
  logic [15:0] interval_q;
  logic [1:0]  select_q;
  logic [7:0]  index_q;
  logic [7:0]  index_d;

  logic             accept;
  logic [7:0]       target;
  logic             in_range;
  logic [1:0]       ptype;
  op_e              op;
  logic [AddrW-1:0] raddr;

  logic             s1_valid_q;
  logic             s1_read_q;
  logic             s1_fresh_q;
  logic [AddrW-1:0] s1_addr_q;
  stage_t           s1_q;
  logic             s1_done;

  logic             fwd_q;
  entry_t           fwd_entry_q;
  logic [Slots-1:0] written_q;

  logic [$bits(entry_t)-1:0] rdata;
  entry_t  cur_entry;
  entry_t  new_entry;
  result_t res;
  logic    we;

  assign cfg_ready_o = 1'b1;

  assign accept   = in_valid_i && !in_stall_o;
  assign target   = (kind_i == KindRead) ? index_q : {5'd0, port_i};
  assign in_range = target < 8'(NUM_PORTS);
  assign ptype    = in_range ? type_of(target, port_types_q) : TypeNone;
  assign raddr    = target[AddrW-1:0];

  always_comb begin
    op = OpIdle;
    unique case (kind_i)
      KindRead: begin
        if (ptype == TypePad) begin
          op = OpPadRd;
        end else if (ptype == TypeMouse) begin
          op = OpMouseRd;
        end
      end
      KindPadUpd: begin
        if (ptype == TypePad) begin
          op = OpPadUpd;
        end
      end
      KindMouseUpd: begin
        if (ptype == TypeMouse) begin
          op = OpMouseUpd;
        end
      end
      default: begin
        op = OpIdle;
      end
    endcase
  end

  always_comb begin
    index_d = index_q;
    if (write_value_i[0] && !select_q[1] && write_value_i[1]) begin
      index_d = 8'd0;
    end else if (write_value_i[0] && !select_q[0] && index_q != IndexMax) begin
      index_d = index_q + 8'd1;
    end
  end

  assign s1_done    = s1_valid_q && (!s1_read_q || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_done;

  assign cur_entry = fwd_q ? fwd_entry_q : (s1_fresh_q ? entry_t'(rdata) : '0);
  assign we        = s1_done && res.we;

  mtp_ram #(
    .Width($bits(entry_t)),
    .Depth(NUM_PORTS),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_addr_q),
    .wdata_i(new_entry),
    .re_i   (accept),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  mtp_port_logic u_logic (
    .item_i    (s1_q),
    .entry_i   (cur_entry),
    .interval_i(interval_q),
    .entry_o   (new_entry),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_types_q <= '0;
      cd_q         <= 1'b0;
      interval_q   <= IntervalReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPortTypes: port_types_q <= cfg_data_i[9:0];
        CfgCd:        cd_q         <= cfg_data_i[0];
        CfgInterval:  interval_q   <= cfg_data_i;
        default:      cd_q         <= cd_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_q <= '0;
      index_q  <= '0;
    end else if (accept && kind_i == KindWrite) begin
      select_q <= write_value_i;
      index_q  <= index_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_read_q  <= 1'b0;
      s1_fresh_q <= 1'b0;
      s1_addr_q  <= '0;
      s1_q       <= '0;
      fwd_q      <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_read_q  <= kind_i == KindRead;
      s1_fresh_q <= written_q[raddr];
      s1_addr_q  <= raddr;
      s1_q.op    <= op;
      s1_q.sel   <= select_q[0];
      s1_q.now   <= now_i;
      s1_q.pad   <= pad_buttons_i;
      s1_q.dx    <= mouse_dx_i;
      s1_q.dy    <= mouse_dy_i;
      s1_q.mbtn  <= mouse_buttons_i;
      fwd_q      <= we && s1_addr_q == raddr;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_entry_q <= new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (we) begin
      written_q[s1_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_done && s1_read_q) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && s1_read_q) begin
      read_data_o <= {!cd_q, 1'b0, 2'b11, res.nibble};
    end
  end

endmodule

`default_nettype wire

// ===== verif/multitap_port_checker.sv =====
// ----------------------------------------------------------------------------
// Multitap port checker
// Follows the register writes and every accepted item on the input channel,
// keeps its own copy of the select lines, port index and per-port pad and
// mouse state, and compares each read byte with the oldest one predicted.
// ----------------------------------------------------------------------------
module multitap_port_checker #(
  parameter int unsigned NUM_PORTS = mtp_pkg::NumPortsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  write_value_i,
  input  logic [31:0] now_i,
  input  logic [2:0]  port_i,
  input  logic [12:0] pad_buttons_i,
  input  logic [31:0] mouse_dx_i,
  input  logic [31:0] mouse_dy_i,
  input  logic [1:0]  mouse_buttons_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [7:0]  read_data_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          faults_o,
  output int          reads_due_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mtp_pkg::*;

  logic [9:0]         types_q;
  logic               cd_q;
  logic [15:0]        interval_q;
  logic [1:0]         lines_q;
  logic [7:0]         index_q;
  logic [12:0]        pad_q     [NUM_PORTS];
  logic               six_on_q  [NUM_PORTS];
  logic               phase_q   [NUM_PORTS];
  logic signed [31:0] acc_x_q   [NUM_PORTS];
  logic signed [31:0] acc_y_q   [NUM_PORTS];
  logic [15:0]        shift_q   [NUM_PORTS];
  logic [1:0]         mbtn_q    [NUM_PORTS];
  logic [31:0]        latched_q [NUM_PORTS];
  logic [7:0]         read_bytes_due [$];
  logic [7:0]         wanted;
  int                 fault_count = 0;
  int                 reads_due = 0;

  assign faults_o    = fault_count;
  assign reads_due_o = reads_due;

  task automatic log_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fault_count++;
  endtask

  function automatic logic [1:0] device_at(int unsigned p);
    logic [1:0] t;
    t = TypeNone;
    if (p < NUM_PORTS && p < TypePorts) begin
      t = types_q[2*p +: 2];
    end
    return (t == TypeAlias) ? TypeNone : t;
  endfunction

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) begin
      s = 64'sd2147483647;
    end
    if (s < -64'sd2147483648) begin
      s = -64'sd2147483648;
    end
    return 32'(s);
  endfunction

  function automatic int motion_clamp(logic signed [31:0] v);
    if (v > 32'sd127) begin
      return 127;
    end
    if (v < -32'sd127) begin
      return -127;
    end
    return int'(v);
  endfunction

  function automatic void latch_motion(int unsigned p, logic [31:0] now);
    logic [31:0] age;
    int          rx;
    int          ry;
    logic [7:0]  bx;
    logic [7:0]  by;
    age = now - latched_q[p];
    if (age <= {16'd0, interval_q}) begin
      return;
    end
    latched_q[p] = now;
    rx = -motion_clamp(acc_x_q[p]);
    ry = -motion_clamp(acc_y_q[p]);
    bx = 8'(rx);
    by = 8'(ry);
    shift_q[p] = {by[3:0], by[7:4], bx[3:0], bx[7:4]};
    acc_x_q[p] = sat_sum(acc_x_q[p], 32'(rx));
    acc_y_q[p] = sat_sum(acc_y_q[p], 32'(ry));
  endfunction

  function automatic logic [7:0] next_read_byte(logic [31:0] now);
    int unsigned p;
    logic        sel;
    logic [3:0]  nib;
    logic [12:0] d;
    p   = index_q;
    sel = lines_q[0];
    nib = 4'h0;
    case (device_at(p))
      TypeMouse: begin
        if (sel) begin
          latch_motion(p, now);
          nib = shift_q[p][3:0];
          shift_q[p] = shift_q[p] >> 4;
        end else begin
          nib = NibbleAll;
          if (mbtn_q[p][0]) begin
            nib[1:0] = 2'b00;
          end
          if (mbtn_q[p][1]) begin
            nib[3] = 1'b0;
          end
        end
      end
      TypePad: begin
        d = pad_q[p];
        if (phase_q[p] && six_on_q[p]) begin
          nib = sel ? 4'h0 : ~d[11:8];
        end else begin
          nib = sel ? ~d[7:4] : ~d[3:0];
        end
        if (!sel) begin
          phase_q[p] = ~phase_q[p];
        end
      end
      default: nib = 4'h0;
    endcase
    return {~cd_q, 1'b0, 2'b11, nib};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      types_q    = '0;
      cd_q       = 1'b0;
      interval_q = IntervalReset;
      lines_q    = '0;
      index_q    = '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        pad_q[i]     = '0;
        six_on_q[i]  = 1'b0;
        phase_q[i]   = 1'b0;
        acc_x_q[i]   = '0;
        acc_y_q[i]   = '0;
        shift_q[i]   = '0;
        mbtn_q[i]    = '0;
        latched_q[i] = '0;
      end
      read_bytes_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgPortTypes: types_q = cfg_data_i[9:0];
          CfgCd:        cd_q = cfg_data_i[0];
          CfgInterval:  interval_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (read_bytes_due.size() == 0) begin
          log_mismatch($sformatf("read_data %02h with no read outstanding",
                                 read_data_o));
        end else begin
          wanted = read_bytes_due.pop_front();
          if (read_data_o !== wanted) begin
            log_mismatch($sformatf("read_data %02h, expected %02h",
                                   read_data_o, wanted));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        case (kind_i)
          KindWrite: begin
            if (write_value_i[0] && !lines_q[1] && write_value_i[1]) begin
              index_q = '0;
            end else if (write_value_i[0] && !lines_q[0] && index_q != IndexMax) begin
              index_q = index_q + 8'd1;
            end
            lines_q = write_value_i;
          end
          KindRead: read_bytes_due.push_back(next_read_byte(now_i));
          KindPadUpd: begin
            if (port_i < NUM_PORTS && device_at(port_i) == TypePad) begin
              if (pad_buttons_i[12] && !pad_q[port_i][12]) begin
                six_on_q[port_i] = ~six_on_q[port_i];
              end
              pad_q[port_i] = pad_buttons_i;
            end
          end
          default: begin
            if (port_i < NUM_PORTS && device_at(port_i) == TypeMouse) begin
              acc_x_q[port_i] = sat_sum(acc_x_q[port_i], mouse_dx_i);
              acc_y_q[port_i] = sat_sum(acc_y_q[port_i], mouse_dy_i);
              mbtn_q[port_i]  = mouse_buttons_i;
            end
          end
        endcase
      end
    end
    reads_due = read_bytes_due.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Multitap port testbench
// Drives port writes, port reads and pad and mouse frame updates through the
// input channel under several register settings and idling patterns; the
// checker beside the block predicts and compares every read byte.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mtp_pkg::*;

  localparam logic [1:0] CfgSpare = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KindWrite;
  logic [1:0]  in_write_value = '0;
  logic [31:0] in_now = '0;
  logic [2:0]  in_port = '0;
  logic [12:0] in_pad = '0;
  logic [31:0] in_dx = '0;
  logic [31:0] in_dy = '0;
  logic [1:0]  in_mbtn = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CfgPortTypes;
  logic [15:0] cfg_data = '0;
  int          faults;
  int          reads_due;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int unsigned items_sent = 0;
  logic [31:0] stamp = '0;

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall = (recv_pct != 0) && ($urandom_range(99) < recv_pct);
  end

  multitap_joypad_mouse_port dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (in_kind),
    .write_value_i   (in_write_value),
    .now_i           (in_now),
    .port_i          (in_port),
    .pad_buttons_i   (in_pad),
    .mouse_dx_i      (in_dx),
    .mouse_dy_i      (in_dy),
    .mouse_buttons_i (in_mbtn),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .read_data_o     (read_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  multitap_port_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (in_kind),
    .write_value_i   (in_write_value),
    .now_i           (in_now),
    .port_i          (in_port),
    .pad_buttons_i   (in_pad),
    .mouse_dx_i      (in_dx),
    .mouse_dy_i      (in_dy),
    .mouse_buttons_i (in_mbtn),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .read_data_o     (read_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .faults_o        (faults),
    .reads_due_o     (reads_due)
  );

  function automatic logic [31:0] next_stamp();
    case ($urandom_range(9))
      0:       stamp = $urandom;
      1, 2, 3: stamp = stamp + $urandom_range(20);
      default: stamp = stamp + $urandom_range(40000);
    endcase
    return stamp;
  endfunction

  function automatic logic [31:0] random_motion();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(600)) - 32'd300;
    endcase
  endfunction

  task automatic drive_item(logic [1:0] kind, logic [1:0] wv, logic [2:0] port,
                            logic [12:0] pad, logic [31:0] dx, logic [31:0] dy,
                            logic [1:0] mbtn);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid       = 1'b1;
    in_kind        = kind;
    in_write_value = wv;
    in_now         = (kind == KindRead) ? next_stamp() : $urandom;
    in_port        = port;
    in_pad         = pad;
    in_dx          = dx;
    in_dy          = dy;
    in_mbtn        = mbtn;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic port_write(logic [1:0] value);
    drive_item(KindWrite, value, 3'($urandom), 13'($urandom), $urandom, $urandom,
               2'($urandom));
  endtask

  task automatic port_read();
    drive_item(KindRead, 2'($urandom), 3'($urandom), 13'($urandom), $urandom,
               $urandom, 2'($urandom));
  endtask

  task automatic random_update();
    logic [2:0] port;
    port = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    if ($urandom_range(1)) begin
      drive_item(KindPadUpd, 2'($urandom), port, 13'($urandom), $urandom, $urandom,
                 2'($urandom));
    end else begin
      drive_item(KindMouseUpd, 2'($urandom), port, 13'($urandom), random_motion(),
                 random_motion(), 2'($urandom));
    end
  endtask

  task automatic write_register(logic [1:0] index, logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_registers(logic [9:0] types, logic cd, logic [15:0] interval);
    in_valid = 1'b0;
    while (reads_due != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    write_register(CfgPortTypes, 16'(types));
    write_register(CfgCd, {15'($urandom), cd});
    write_register(CfgInterval, interval);
    write_register(CfgSpare, 16'($urandom));
    cfg_valid = 1'b0;
  endtask

  task automatic run_traffic(int unsigned n);
    int unsigned goal;
    goal = items_sent + n;
    while (items_sent < goal) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          port_write(2'b01);
          port_write(2'b11);
          repeat ($urandom_range(1, 7)) begin
            repeat ($urandom_range(1, 4)) port_read();
            if ($urandom_range(3) == 0) begin
              random_update();
            end
            port_write({1'($urandom_range(1)), 1'b0});
            repeat ($urandom_range(1, 2)) port_read();
            port_write(2'b01);
          end
        end
        6, 7: repeat ($urandom_range(1, 4)) random_update();
        default: begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1)) begin
              port_write(2'($urandom));
            end else begin
              port_read();
            end
          end
        end
      endcase
    end
  endtask

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    // Pads on ports 0, 2 and 4, mice on ports 1 and 3.
    set_registers(10'h199, 1'b0, 16'd0);

    drive_item(KindPadUpd, 2'b00, 3'd0, 13'h1FFF, '0, '0, 2'b00);
    drive_item(KindMouseUpd, 2'b00, 3'd1, '0, 32'h7FFF_FFFF, 32'h8000_0000, 2'b11);
    drive_item(KindMouseUpd, 2'b00, 3'd1, '0, 32'h7FFF_FFFF, 32'h8000_0000, 2'b11);
    drive_item(KindPadUpd, 2'b11, 3'd7, 13'h1FFF, '1, '1, 2'b11);
    drive_item(KindPadUpd, 2'b11, 3'd1, 13'h0ABC, '1, '1, 2'b11);
    drive_item(KindMouseUpd, 2'b11, 3'd0, 13'h1FFF, 32'd5, 32'd5, 2'b01);
    port_write(2'b01);
    port_write(2'b11);
    port_read();
    port_write(2'b00);
    port_read();
    port_read();
    port_write(2'b01);
    repeat (5) port_read();
    port_write(2'b00);
    port_read();
    port_write(2'b11);
    port_write(2'b10);
    port_write(2'b11);
    port_read();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: set_registers(10'h266, 1'b1, 16'hFFFF);
        2: set_registers(10'h3FF, 1'b0, IntervalReset);
        3: set_registers(10'h000, 1'b1, 16'd1);
        default: set_registers(10'($urandom), 1'($urandom),
                               $urandom_range(1) ? 16'($urandom_range(50))
                                                 : 16'($urandom));
      endcase
      case (ph % 4)
        0: begin
          send_pct = 0;
          recv_pct = 0;
        end
        1: begin
          send_pct = 46;
          recv_pct = 0;
        end
        2: begin
          send_pct = 0;
          recv_pct = 46;
        end
        default: begin
          send_pct = 12;
          recv_pct = 12;
        end
      endcase
      if (ph == 0) begin
        // Walk the port index up until it saturates.
        port_write(2'b01);
        port_write(2'b11);
        repeat (260) begin
          port_write(2'b00);
          port_write(2'b01);
        end
        port_read();
        port_write(2'b00);
        port_read();
      end
      run_traffic(10);
    end

    in_valid = 1'b0;
    while (reads_due != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
